// ===== src/nd_index_linearizer_macros.svh =====
// Assertion macros for the index linearizer RTL.
`ifndef ND_INDEX_LINEARIZER_MACROS_SVH
`define ND_INDEX_LINEARIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NDL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define NDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NDL_ASSERT(lbl, clk, rstn, prop, msg)
`define NDL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/ndl_pkg.sv =====
// Types, constants and the divider step function of the index linearizer.
`timescale 1ns / 1ps
`default_nettype none
package ndl_pkg;

    localparam int FIELD_DIMS    = 4;
    localparam int NUM_DIV       = FIELD_DIMS - 1;
    localparam int STEP_BITS     = 4;
    localparam int STEPS_PER_DIM = 32 / STEP_BITS;
    localparam int DIV_STAGES    = NUM_DIV * STEPS_PER_DIM;

    typedef enum logic [2:0] {
        REG_NUM_DIMS = 3'd0,
        REG_EXTENT_0 = 3'd1,
        REG_EXTENT_1 = 3'd2,
        REG_EXTENT_2 = 3'd3,
        REG_EXTENT_3 = 3'd4
    } reg_index_t;

    typedef enum logic {
        OP_TO_LINEAR  = 1'b0,
        OP_TO_INDICES = 1'b1
    } opcode_t;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  in_index_0;
        logic [7:0]  in_index_1;
        logic [7:0]  in_index_2;
        logic [7:0]  in_index_3;
        logic [31:0] in_linear;
    } ndl_req_t;

    typedef struct packed {
        logic [31:0] out_linear;
        logic [7:0]  out_index_0;
        logic [7:0]  out_index_1;
        logic [7:0]  out_index_2;
        logic [7:0]  out_index_3;
        logic        out_of_range;
    } ndl_rsp_t;

    // Effective configuration: dims in 1..4, extents in 1..256
    typedef struct packed {
        logic [2:0]                       dims;
        logic [FIELD_DIMS-1:0][8:0]       ext;
    } ndl_cfg_t;

    typedef struct packed {
        logic                    op;
        logic                    oor;
        logic [7:0]              i0;
        logic [7:0]              i1;
        logic [7:0]              i2;
        logic [31:0]             acc;
        logic [31:0]             q;
        logic [8:0]              r;
        logic [NUM_DIV-1:0][7:0] rem;
        logic [31:0]             top;
    } ndl_item_t;

    typedef struct packed {
        logic [31:0] q;
        logic [8:0]  r;
    } ndl_div_t;

    // Restoring division, STEP_BITS quotient bits shifted into q
    function automatic ndl_div_t div_step(logic [31:0] q, logic [8:0] r, logic [8:0] e);
        logic [31:0] qq;
        logic [8:0]  rr;
        ndl_div_t    res;
        qq = q;
        rr = r;
        for (int b = 0; b < STEP_BITS; b++) begin
            rr = {rr[7:0], qq[31]};
            qq = {qq[30:0], 1'b0};
            if (rr >= e)
            begin
                rr = rr - e;
                qq[0] = 1'b1;
            end
        end
        res.q = qq;
        res.r = rr;
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/ndl_pipe.sv =====
// Pipelined datapath: Horner multiply-add for offsets, staged divider for indices.
`timescale 1ns / 1ps
`default_nettype none
`include "nd_index_linearizer_macros.svh"
module ndl_pipe (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ndl_pkg::ndl_cfg_t cfg,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire ndl_pkg::ndl_req_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output ndl_pkg::ndl_rsp_t     rsp
);
    import ndl_pkg::*;

    ndl_item_t               stg_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]   v_reg;
    logic [DIV_STAGES:0]     free_w;
    ndl_item_t               init_w;
    ndl_rsp_t                rsp_next;

    // Stage 0 input: unused dimensions read as zero
    always_comb
    begin
        init_w     = '0;
        init_w.op  = req.opcode;
        init_w.i0  = req.in_index_0;
        init_w.i1  = (cfg.dims >= 3'd2) ? req.in_index_1 : 8'd0;
        init_w.i2  = (cfg.dims >= 3'd3) ? req.in_index_2 : 8'd0;
        init_w.acc = (cfg.dims >= 3'd4) ? 32'(req.in_index_3) : 32'd0;
        init_w.q   = req.in_linear;
        init_w.oor = ({1'b0, req.in_index_0} >= cfg.ext[0])
                   || ((cfg.dims >= 3'd2) && ({1'b0, req.in_index_1} >= cfg.ext[1]))
                   || ((cfg.dims >= 3'd3) && ({1'b0, req.in_index_2} >= cfg.ext[2]))
                   || ((cfg.dims >= 3'd4) && ({1'b0, req.in_index_3} >= cfg.ext[3]));
    end

    assign free_w[DIV_STAGES] = !rsp_valid || !rsp_stall;
    assign req_stall          = !free_w[0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int DIM  = k / STEPS_PER_DIM;
        localparam int STEP = k % STEPS_PER_DIM;
        ndl_item_t cur;
        ndl_item_t nxt;
        ndl_div_t  ds;
        logic      vin;

        if (k == 0)
        begin : g_first
            assign cur = init_w;
            assign vin = req_valid;
        end
        else
        begin : g_rest
            assign cur = stg_reg[k-1];
            assign vin = v_reg[k-1];
        end

        always_comb
        begin
            nxt = cur;
            ds  = div_step(cur.q, (STEP == 0) ? 9'd0 : cur.r, cfg.ext[DIM]);
            if ((STEP == 0) && (cfg.dims == 3'(DIM + 1)))
            begin
                nxt.top = cur.q;
            end
            nxt.q = ds.q;
            nxt.r = ds.r;
            if (STEP == STEPS_PER_DIM - 1)
            begin
                nxt.rem[DIM] = ds.r[7:0];
            end
            if (k == STEPS_PER_DIM)
            begin
                nxt.acc = 32'(cur.acc * 32'(cfg.ext[2]) + 32'(cur.i2));
            end
            if (k == 2 * STEPS_PER_DIM)
            begin
                nxt.acc = 32'(cur.acc * 32'(cfg.ext[1]) + 32'(cur.i1));
            end
        end

        assign free_w[k] = !v_reg[k] || free_w[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (free_w[k])
            begin
                v_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (free_w[k] && vin)
            begin
                stg_reg[k] <= nxt;
            end
        end
    end

    // Final stage: last multiply-add, bound check on the top quotient, field select
    always_comb
    begin
        ndl_item_t   s;
        logic [31:0] top_v;
        logic [1:0]  top_d;
        logic [7:0]  idx [FIELD_DIMS];
        s     = stg_reg[DIV_STAGES-1];
        top_v = (cfg.dims == 3'(FIELD_DIMS)) ? s.q : s.top;
        top_d = 2'(cfg.dims - 3'd1);
        for (int d = 0; d < FIELD_DIMS; d++)
        begin
            if (d < NUM_DIV && 3'(d + 1) < cfg.dims)
            begin
                idx[d] = s.rem[d < NUM_DIV ? d : 0];
            end
            else if (3'(d + 1) == cfg.dims)
            begin
                idx[d] = top_v[7:0];
            end
            else
            begin
                idx[d] = 8'd0;
            end
        end
        rsp_next = '0;
        if (s.op == OP_TO_LINEAR)
        begin
            rsp_next.out_linear   = 32'(s.acc * 32'(cfg.ext[0]) + 32'(s.i0));
            rsp_next.out_of_range = s.oor;
        end
        else
        begin
            rsp_next.out_index_0  = idx[0];
            rsp_next.out_index_1  = idx[1];
            rsp_next.out_index_2  = idx[2];
            rsp_next.out_index_3  = idx[3];
            rsp_next.out_of_range = (top_v >= 32'(cfg.ext[top_d]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid <= 1'b0;
        end
        else if (free_w[DIV_STAGES])
        begin
            rsp_valid <= v_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_w[DIV_STAGES] && v_reg[DIV_STAGES-1])
        begin
            rsp <= rsp_next;
        end
    end

    `NDL_ASSERT(a_enter, clk, rst_n, req_valid && !req_stall |=> v_reg[0], "accepted transaction not in stage 0")
    `NDL_ASSERT(a_hold0, clk, rst_n, v_reg[0] && !free_w[1] |=> v_reg[0] && $stable(stg_reg[0]), "stage 0 lost a held item")
    `NDL_ASSERT(a_lin_zero, clk, rst_n, v_reg[DIV_STAGES-1] && free_w[DIV_STAGES] && stg_reg[DIV_STAGES-1].op |=> rsp.out_linear == 32'd0, "index result carries an offset")

endmodule
`default_nettype wire

// ===== src/nd_index_linearizer.sv =====
// Top level: configuration registers and the conversion pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Column-major index <-> flat offset converter for up to four dimensions.
// Accepts one transaction per cycle while the response side does not stall. The
// result passes through the divider: three divisions by an extent, each spread over
// eight stages that retire four quotient bits apiece, then one output stage that
// does the final multiply-add and bound check. Offsets wrap to 32 bits and the
// top index to 8 bits; out_of_range flags either case. Write configuration only
// while no transaction is in flight; cfg_ready is always high.
module nd_index_linearizer #(
    parameter int MAX_DIMS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [8:0]        cfg_data,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire ndl_pkg::ndl_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output ndl_pkg::ndl_rsp_t      rsp
);
    import ndl_pkg::*;

    localparam int DIM_CAP = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;

    logic [2:0]                 num_dims_reg;
    logic [FIELD_DIMS-1:0][8:0] extent_reg;
    ndl_cfg_t                   cfg_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= 3'd1;
            for (int d = 0; d < FIELD_DIMS; d++)
            begin
                extent_reg[d] <= 9'd1;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NUM_DIMS: num_dims_reg  <= cfg_data[2:0];
                REG_EXTENT_0: extent_reg[0] <= cfg_data;
                REG_EXTENT_1: extent_reg[1] <= cfg_data;
                REG_EXTENT_2: extent_reg[2] <= cfg_data;
                REG_EXTENT_3: extent_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp: zero dims means one, dims cap at MAX_DIMS (at most four), extent zero means one, extents cap at 256
    always_comb
    begin
        if (num_dims_reg == 3'd0)
        begin
            cfg_eff.dims = 3'd1;
        end
        else if (32'(num_dims_reg) > DIM_CAP)
        begin
            cfg_eff.dims = 3'(DIM_CAP);
        end
        else
        begin
            cfg_eff.dims = num_dims_reg;
        end
        for (int d = 0; d < FIELD_DIMS; d++)
        begin
            if (extent_reg[d] == 9'd0)
            begin
                cfg_eff.ext[d] = 9'd1;
            end
            else if (extent_reg[d] > 9'd256)
            begin
                cfg_eff.ext[d] = 9'd256;
            end
            else
            begin
                cfg_eff.ext[d] = extent_reg[d];
            end
        end
    end

    ndl_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_eff),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// ===== tb/nd_index_linearizer_tb.sv =====
// Self-checking testbench for the column-major index linearizer.
`timescale 1ns / 1ps
`default_nettype none
module nd_index_linearizer_tb;
    import ndl_pkg::*;

    class offset_scoreboard;
        logic [2:0] num_dims;
        logic [8:0] extent [4];
        ndl_rsp_t   pending [$];
        int         errors;

        function void clear_config();
            num_dims = 3'd1;
            for (int d = 0; d < 4; d++)
            begin
                extent[d] = 9'd1;
            end
            errors = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [8:0] data);
            case (idx)
                REG_NUM_DIMS: num_dims = data[2:0];
                REG_EXTENT_0: extent[0] = data;
                REG_EXTENT_1: extent[1] = data;
                REG_EXTENT_2: extent[2] = data;
                REG_EXTENT_3: extent[3] = data;
                default: ;
            endcase
        endfunction

        // Compute the expected conversion and queue it
        function void note_request(ndl_req_t r);
            longint unsigned ext [4];
            longint unsigned stride [4];
            longint unsigned total;
            longint unsigned lin;
            longint unsigned rest;
            logic [7:0]      idx_in [4];
            logic [7:0]      idx_out [4];
            int              dims;
            ndl_rsp_t        e;
            dims = num_dims;
            if (dims < 1) dims = 1;
            if (dims > 4) dims = 4;
            for (int d = 0; d < 4; d++)
            begin
                ext[d] = (extent[d] == 0) ? 1 : (extent[d] > 256 ? 256 : extent[d]);
                idx_out[d] = 8'd0;
            end
            stride[0] = 1;
            for (int d = 1; d < 4; d++)
            begin
                stride[d] = stride[d-1] * ext[d-1];
            end
            total = stride[dims-1] * ext[dims-1];
            idx_in[0] = r.in_index_0;
            idx_in[1] = r.in_index_1;
            idx_in[2] = r.in_index_2;
            idx_in[3] = r.in_index_3;
            e = '0;
            if (opcode_t'(r.opcode) == OP_TO_LINEAR)
            begin
                lin = 0;
                for (int d = 0; d < dims; d++)
                begin
                    if (idx_in[d] >= ext[d]) e.out_of_range = 1'b1;
                    lin += idx_in[d] * stride[d];
                end
                e.out_linear = lin[31:0];
            end
            else
            begin
                rest = r.in_linear;
                if (rest >= total) e.out_of_range = 1'b1;
                for (int d = dims - 1; d >= 0; d--)
                begin
                    idx_out[d] = 8'(rest / stride[d]);
                    rest = rest % stride[d];
                end
            end
            e.out_index_0 = idx_out[0];
            e.out_index_1 = idx_out[1];
            e.out_index_2 = idx_out[2];
            e.out_index_3 = idx_out[3];
            pending.push_back(e);
        endfunction

        function void check_response(ndl_rsp_t a);
            ndl_rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected transaction %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.out_linear !== e.out_linear)
            begin
                $error("out_linear exp %h got %h", e.out_linear, a.out_linear);
                errors++;
            end
            if (a.out_index_0 !== e.out_index_0)
            begin
                $error("out_index_0 exp %h got %h", e.out_index_0, a.out_index_0);
                errors++;
            end
            if (a.out_index_1 !== e.out_index_1)
            begin
                $error("out_index_1 exp %h got %h", e.out_index_1, a.out_index_1);
                errors++;
            end
            if (a.out_index_2 !== e.out_index_2)
            begin
                $error("out_index_2 exp %h got %h", e.out_index_2, a.out_index_2);
                errors++;
            end
            if (a.out_index_3 !== e.out_index_3)
            begin
                $error("out_index_3 exp %h got %h", e.out_index_3, a.out_index_3);
                errors++;
            end
            if (a.out_of_range !== e.out_of_range)
            begin
                $error("out_of_range exp %b got %b", e.out_of_range, a.out_of_range);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 25;
    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [8:0] cfg_data;
    logic       req_valid;
    logic       req_stall;
    ndl_req_t   req;
    logic       rsp_valid;
    logic       rsp_stall;
    ndl_rsp_t   rsp;

    offset_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycle_count;

    nd_index_linearizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Receiver: check accepted results, randomize stall for the next edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall) sb.check_response(rsp);
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("nd_index_linearizer: mismatch");
            $finish;
        end
    end

    // Hold valid across consecutive writes; the caller drops it
    task automatic write_reg(reg_index_t idx, logic [8:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_shape(logic [2:0] dims, logic [8:0] e0, logic [8:0] e1,
                             logic [8:0] e2, logic [8:0] e3);
        write_reg(REG_NUM_DIMS, {6'd0, dims});
        write_reg(REG_EXTENT_0, e0);
        write_reg(REG_EXTENT_1, e1);
        write_reg(REG_EXTENT_2, e2);
        write_reg(REG_EXTENT_3, e3);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the transaction until accepted; drop valid only on a gap
    task automatic send(ndl_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        sb.note_request(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_index(logic [8:0] ext);
        int m;
        m = (ext == 0) ? 1 : (ext > 256 ? 256 : ext);
        case ($urandom_range(9))
            0: return 8'($urandom);
            1: return 8'(m - 1);
            default: return 8'($urandom_range(m - 1));
        endcase
    endfunction

    function automatic ndl_req_t random_req();
        ndl_req_t   r;
        longint unsigned total;
        int dims;
        r.opcode     = 1'($urandom_range(1));
        r.in_index_0 = pick_index(sb.extent[0]);
        r.in_index_1 = pick_index(sb.extent[1]);
        r.in_index_2 = pick_index(sb.extent[2]);
        r.in_index_3 = pick_index(sb.extent[3]);
        dims = (sb.num_dims < 1) ? 1 : (sb.num_dims > 4 ? 4 : sb.num_dims);
        total = 1;
        for (int d = 0; d < dims; d++)
        begin
            total *= (sb.extent[d] == 0) ? 1 : (sb.extent[d] > 256 ? 256 : sb.extent[d]);
        end
        case ($urandom_range(9))
            0: r.in_linear = $urandom;
            1: r.in_linear = 32'(total - 1);
            2: r.in_linear = 32'(total);
            default: r.in_linear = 32'({$urandom, $urandom} % total);
        endcase
        return r;
    endfunction

    task automatic send_fields(opcode_t op, logic [7:0] i0, logic [7:0] i1,
                               logic [7:0] i2, logic [7:0] i3, logic [31:0] lin);
        ndl_req_t r;
        r.opcode = op;
        r.in_index_0 = i0;
        r.in_index_1 = i1;
        r.in_index_2 = i2;
        r.in_index_3 = i3;
        r.in_linear = lin;
        send(r);
    endtask

    initial
    begin
        sb = new();
        sb.clear_config();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset shape: a single element
        send_fields(OP_TO_LINEAR, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        send_fields(OP_TO_INDICES, 8'd0, 8'd0, 8'd0, 8'd0, 32'd1);
        drain();

        // Full 256^4 space: offsets span all 32 bits, top index reaches 255
        set_shape(3'd4, 9'd256, 9'd256, 9'd256, 9'd256);
        send_fields(OP_TO_LINEAR, 8'hff, 8'hff, 8'hff, 8'hff, 32'd0);
        send_fields(OP_TO_LINEAR, 8'h00, 8'h00, 8'h00, 8'h00, 32'hffffffff);
        send_fields(OP_TO_INDICES, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff);
        send_fields(OP_TO_INDICES, 8'h00, 8'h00, 8'h00, 8'h00, 32'h00000000);
        drain();

        // Zero count, zero extents, oversize extents and count
        set_shape(3'd0, 9'd0, 9'd300, 9'd511, 9'd0);
        send_fields(OP_TO_LINEAR, 8'd0, 8'd7, 8'd7, 8'd7, 32'd0);
        send_fields(OP_TO_LINEAR, 8'd1, 8'd0, 8'd0, 8'd0, 32'd0);
        send_fields(OP_TO_INDICES, 8'd0, 8'd0, 8'd0, 8'd0, 32'd5);
        drain();
        set_shape(3'd7, 9'd3, 9'd511, 9'd0, 9'd5);
        send_fields(OP_TO_LINEAR, 8'd2, 8'd255, 8'd0, 8'd4, 32'd0);
        send_fields(OP_TO_LINEAR, 8'd3, 8'd0, 8'd1, 8'd5, 32'd0);
        send_fields(OP_TO_INDICES, 8'd0, 8'd0, 8'd0, 8'd0, 32'd3839);
        send_fields(OP_TO_INDICES, 8'd0, 8'd0, 8'd0, 8'd0, 32'd3840);
        drain();

        // Unused dimensions ignore their indices
        set_shape(3'd2, 9'd10, 9'd20, 9'd1, 9'd1);
        send_fields(OP_TO_LINEAR, 8'd9, 8'd19, 8'd200, 8'd200, 32'd0);
        send_fields(OP_TO_LINEAR, 8'd10, 8'd20, 8'd0, 8'd0, 32'd0);
        send_fields(OP_TO_INDICES, 8'd0, 8'd0, 8'd0, 8'd0, 32'd199);
        send_fields(OP_TO_INDICES, 8'd0, 8'd0, 8'd0, 8'd0, 32'd200);
        drain();

        // Random shapes, plus fixed full and all-ones shapes, over three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1 ? 84 : 0);
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1 ? 20 : 0);
            for (int s = 0; s < 6; s++)
            begin
                if (s == 0 && phase == 2)
                    set_shape(3'd4, 9'd1, 9'd1, 9'd1, 9'd1);
                else if (s == 1)
                    set_shape(3'd4, 9'd256, 9'd256, 9'd256, 9'd256);
                else
                    set_shape(3'($urandom_range(7)), 9'($urandom_range(511)),
                              9'($urandom_range(300)), 9'($urandom_range(300)),
                              9'($urandom_range(511)));
                repeat (40) send(random_req());
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("nd_index_linearizer: match");
        else
            $display("nd_index_linearizer: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
